FILE: hw/rtl/qsrt_pkg.sv
// ----------------------------------------------------------------------------
// qsrt_pkg
// shared constants, request codes, control words and sequence compares
// for the quiescent-state reclaim tracker
// ----------------------------------------------------------------------------
package qsrt_pkg;

	localparam int QSRT_SLOT_COUNT = 16;

	localparam logic [63:0] SEQ_OFFLINE = 64'd0;
	localparam logic [63:0] SEQ_INITIAL = 64'd1;
	localparam logic [63:0] SEQ_INCR    = 64'd2;

	localparam logic [2:0] REQ_ADVANCE    = 3'd0;
	localparam logic [2:0] REQ_POLL       = 3'd1;
	localparam logic [2:0] REQ_ONLINE     = 3'd2;
	localparam logic [2:0] REQ_OFFLINE    = 3'd3;
	localparam logic [2:0] REQ_REGISTER   = 3'd4;
	localparam logic [2:0] REQ_UNREGISTER = 3'd5;

	typedef struct packed {
		logic load;
		logic decode;
		logic scan_step;
		logic update;
		logic reply;
		logic alloc_step;
	} qsrt_cmd_t;

	typedef struct packed {
		logic is_poll;
		logic is_reg;
		logic poll_hit;
		logic scan_end;
		logic alloc_end;
	} qsrt_stat_t;

	function automatic logic seq_before(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		return d[63];
	endfunction

	function automatic logic seq_at_or_before(input logic [63:0] a, input logic [63:0] b);
		return (a == b) || seq_before(a, b);
	endfunction

endpackage

FILE: hw/rtl/qsrt_ram.sv
// ----------------------------------------------------------------------------
// qsrt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module qsrt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/qsrt_datapath.sv
// ----------------------------------------------------------------------------
// qsrt_datapath
// sequence registers, slot flags, slot sequence ram, scan and allocation
// counter, and the registered result word
// ----------------------------------------------------------------------------
module qsrt_datapath #(
	parameter int SLOT_COUNT = qsrt_pkg::QSRT_SLOT_COUNT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            req_type,
	input  logic [3:0]            slot,
	input  logic [63:0]           goal,
	input  qsrt_pkg::qsrt_cmd_t   cmd,
	output qsrt_pkg::qsrt_stat_t  stat,
	output logic                  done,
	output logic                  reached,
	output logic [63:0]           seq_value,
	output logic [3:0]            slot_granted,
	output logic                  status
);
	import qsrt_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int XW = (IW > 4) ? IW : 4;
	localparam int KW = XW + 1;
	localparam logic [CW-1:0] CntLast = CW'(SLOT_COUNT - 1);
	localparam logic [CW-1:0] CntEnd  = CW'(SLOT_COUNT);
	localparam logic [KW-1:0] SlotLim = KW'(SLOT_COUNT);

	logic [2:0]            req_q;
	logic [3:0]            slot_q;
	logic [63:0]           goal_q;
	logic [63:0]           write_seq_q;
	logic [63:0]           read_seq_q;
	logic [63:0]           min_q;
	logic [CW-1:0]         cnt_q;
	logic                  pend_s1;
	logic                  valid_s1;
	logic [SLOT_COUNT-1:0] busy_q;
	logic [SLOT_COUNT-1:0] valid_q;

	logic                  done_q;
	logic                  reached_q;
	logic [63:0]           seq_value_q;
	logic [3:0]            slot_granted_q;
	logic                  status_q;

	logic [XW-1:0]         slot_x;
	logic [IW-1:0]         slot_idx;
	logic                  slot_ok;
	logic [IW-1:0]         cnt_idx;
	logic [XW-1:0]         cnt_x;
	logic                  issue;
	logic                  slot_free;
	logic [63:0]           write_inc;
	logic [63:0]           ram_rdata;
	logic [63:0]           scan_val;
	logic                  ram_we;

	logic                  res_vld;
	logic                  res_reached;
	logic [63:0]           res_seq;
	logic [3:0]            res_grant;
	logic                  res_status;

	assign slot_x    = XW'(slot_q);
	assign slot_idx  = slot_x[IW-1:0];
	assign slot_ok   = KW'(slot_q) < SlotLim;
	assign cnt_idx   = cnt_q[IW-1:0];
	assign cnt_x     = XW'(cnt_idx);
	assign issue     = cmd.scan_step && (cnt_q != CntEnd);
	assign slot_free = !busy_q[cnt_idx];
	assign write_inc = write_seq_q + SEQ_INCR;
	assign scan_val  = valid_s1 ? ram_rdata : SEQ_OFFLINE;
	assign ram_we    = cmd.decode && (req_q == REQ_ONLINE) && slot_ok;

	assign stat.is_poll   = (req_q == REQ_POLL);
	assign stat.is_reg    = (req_q == REQ_REGISTER);
	assign stat.poll_hit  = seq_at_or_before(goal_q, read_seq_q);
	assign stat.scan_end  = (cnt_q == CntEnd) && !pend_s1;
	assign stat.alloc_end = slot_free || (cnt_q == CntLast);

	qsrt_ram #(
		.WIDTH(64),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_idx),
		.wdata(write_seq_q),
		.re   (issue),
		.raddr(cnt_idx),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_vld     = 1'b0;
		res_reached = 1'b0;
		res_seq     = '0;
		res_grant   = '0;
		res_status  = 1'b0;
		if (cmd.decode) begin
			case (req_q)
				REQ_ADVANCE: begin
					res_vld = 1'b1;
					res_seq = write_inc;
				end
				REQ_POLL: begin
					if (stat.poll_hit) begin
						res_vld     = 1'b1;
						res_reached = 1'b1;
						res_seq     = read_seq_q;
					end
				end
				REQ_REGISTER: begin
					res_vld = 1'b0;
				end
				default: begin
					res_vld = 1'b1;
				end
			endcase
		end
		if (cmd.reply) begin
			res_vld     = 1'b1;
			res_reached = seq_at_or_before(goal_q, read_seq_q);
			res_seq     = read_seq_q;
		end
		if (cmd.alloc_step && stat.alloc_end) begin
			res_vld    = 1'b1;
			res_grant  = slot_free ? cnt_x[3:0] : 4'd0;
			res_status = !slot_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q          <= REQ_ADVANCE;
			write_seq_q    <= SEQ_INITIAL;
			read_seq_q     <= SEQ_INITIAL;
			cnt_q          <= '0;
			pend_s1        <= 1'b0;
			busy_q         <= '0;
			valid_q        <= '0;
			done_q         <= 1'b0;
			reached_q      <= 1'b0;
			seq_value_q    <= '0;
			slot_granted_q <= '0;
			status_q       <= 1'b0;
		end else begin
			done_q <= res_vld;
			if (res_vld) begin
				reached_q      <= res_reached;
				seq_value_q    <= res_seq;
				slot_granted_q <= res_grant;
				status_q       <= res_status;
			end
			if (cmd.load) begin
				req_q   <= req_type;
				cnt_q   <= '0;
				pend_s1 <= 1'b0;
			end
			if (cmd.decode) begin
				case (req_q)
					REQ_ADVANCE: begin
						write_seq_q <= write_inc;
					end
					REQ_ONLINE: begin
						if (slot_ok) begin
							valid_q[slot_idx] <= 1'b1;
						end
					end
					REQ_OFFLINE: begin
						if (slot_ok) begin
							valid_q[slot_idx] <= 1'b0;
						end
					end
					REQ_UNREGISTER: begin
						if (slot_ok) begin
							busy_q[slot_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan_step) begin
				pend_s1 <= issue;
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.update && seq_before(read_seq_q, min_q)) begin
				read_seq_q <= min_q;
			end
			if (cmd.alloc_step) begin
				if (slot_free) begin
					busy_q[cnt_idx] <= 1'b1;
				end else if (cnt_q != CntLast) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// request capture and running minimum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q <= slot;
			goal_q <= goal;
			min_q  <= write_seq_q;
		end
		if (cmd.scan_step) begin
			valid_s1 <= valid_q[cnt_idx];
			if (pend_s1 && (scan_val != SEQ_OFFLINE) && seq_before(scan_val, min_q)) begin
				min_q <= scan_val;
			end
		end
	end

	assign done         = done_q;
	assign reached      = reached_q;
	assign seq_value    = seq_value_q;
	assign slot_granted = slot_granted_q;
	assign status       = status_q;

endmodule

FILE: hw/rtl/qsrt_ctrl.sv
// ----------------------------------------------------------------------------
// qsrt_ctrl
// request sequencer: decode, poll scan, read sequence update, slot allocation
// ----------------------------------------------------------------------------
module qsrt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  qsrt_pkg::qsrt_stat_t stat,
	output qsrt_pkg::qsrt_cmd_t  cmd
);
	import qsrt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_UPDATE = 6'b001000,
		ST_REPLY  = 6'b010000,
		ST_ALLOC  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.is_reg) begin
					state_nxt = ST_ALLOC;
				end else if (stat.is_poll && !stat.poll_hit) begin
					state_nxt = ST_SCAN;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_end) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = ST_REPLY;
			end
			ST_REPLY: begin
				cmd.reply = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_ALLOC: begin
				cmd.alloc_step = 1'b1;
				if (stat.alloc_end) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/quiescent_state_reclaim_tracker_core.sv
// ----------------------------------------------------------------------------
// quiescent_state_reclaim_tracker_core
// result strobe: registered from decode for advance, online, offline, unregister,
// unknown requests and polls already reached; from reply after scan and update
// for a poll that scans the slot ram (one read per cycle); from the allocation
// step for register (one slot flag tested per cycle). one word in flight; next
// start taken in the cycle the result strobe is high. results cannot be stalled.
// reset: asynchronous, active low; sequences back to 1, all slots free/offline
// ----------------------------------------------------------------------------
module quiescent_state_reclaim_tracker_core #(
	parameter int SLOT_COUNT = qsrt_pkg::QSRT_SLOT_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [3:0]  slot,
	input  logic [63:0] goal,
	output logic        done,
	output logic        reached,
	output logic [63:0] seq_value,
	output logic [3:0]  slot_granted,
	output logic        status
);
	import qsrt_pkg::*;

	qsrt_cmd_t  cmd;
	qsrt_stat_t stat;

	qsrt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	qsrt_datapath #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.slot        (slot),
		.goal        (goal),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.reached     (reached),
		.seq_value   (seq_value),
		.slot_granted(slot_granted),
		.status      (status)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result strobes back to back");

	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (slot_granted == 4'd0 && seq_value == 64'd0 && !reached))
		else $error("full pool result carries nonzero fields");
`endif

endmodule

FILE: verif/tb_quiescent_state_reclaim_tracker_core.sv
// ----------------------------------------------------------------------------
// tb_quiescent_state_reclaim_tracker_core
// self-checking bench for the grace-period tracker: a directed table of
// requests, then random request streams with register/unregister phases,
// all sent over start/busy with random gaps; each done word is compared
// field by field against the expected reply from the table for typed rows,
// else against a local model of the sequences and the slot pool
module tb_quiescent_state_reclaim_tracker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import qsrt_pkg::*;

	localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
	localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = QSRT_SLOT_COUNT + 8;
	localparam int MAX_REPORTS = 10;
	localparam int NUM_ROWS = 25;

	typedef struct packed {
		logic        reached;
		logic [63:0] seq_value;
		logic [3:0]  slot_granted;
		logic        status;
	} reply_t;

	typedef struct {
		logic [2:0]  req;
		logic [3:0]  slot;
		logic [63:0] goal;
		int          reps;
		bit          typed;
		reply_t      reply;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [3:0]  slot;
	logic [63:0] goal;
	logic        done;
	logic        reached;
	logic [63:0] seq_value;
	logic [3:0]  slot_granted;
	logic        status;

	// local copy of the tracker state
	logic [63:0] model_write;
	logic [63:0] model_read;
	logic [63:0] model_slot_seq [QSRT_SLOT_COUNT];
	bit          model_slot_busy [QSRT_SLOT_COUNT];

	reply_t pending_replies [$];
	int     mismatch_count;
	int     no_gap_left;
	row_t   directed_rows [NUM_ROWS];

	quiescent_state_reclaim_tracker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.slot         (slot),
		.goal         (goal),
		.done         (done),
		.reached      (reached),
		.seq_value    (seq_value),
		.slot_granted (slot_granted),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit seq_precedes(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] diff;
		diff = a - b;
		return diff[63];
	endfunction

	function automatic void grace_reset();
		model_write = SEQ_INITIAL;
		model_read = SEQ_INITIAL;
		for (int i = 0; i < QSRT_SLOT_COUNT; i++) begin
			model_slot_seq[i] = SEQ_OFFLINE;
			model_slot_busy[i] = 1'b0;
		end
	endfunction

	function automatic reply_t grace_step(input logic [2:0] rq, input logic [3:0] sl,
			input logic [63:0] gl);
		reply_t r;
		logic [63:0] oldest;
		r = '0;
		case (rq)
			REQ_ADVANCE: begin
				model_write = model_write + SEQ_INCR;
				r.seq_value = model_write;
			end
			REQ_POLL: begin
				if (gl == model_read || seq_precedes(gl, model_read)) begin
					r.reached = 1'b1;
				end else begin
					oldest = model_write;
					for (int i = 0; i < QSRT_SLOT_COUNT; i++) begin
						if (model_slot_seq[i] != SEQ_OFFLINE
								&& seq_precedes(model_slot_seq[i], oldest))
							oldest = model_slot_seq[i];
					end
					if (seq_precedes(model_read, oldest))
						model_read = oldest;
					r.reached = (gl == model_read) || seq_precedes(gl, model_read);
				end
				r.seq_value = model_read;
			end
			REQ_ONLINE: begin
				model_slot_seq[sl] = model_write;
			end
			REQ_OFFLINE: begin
				model_slot_seq[sl] = SEQ_OFFLINE;
			end
			REQ_REGISTER: begin
				r.status = 1'b1;
				for (int i = 0; i < QSRT_SLOT_COUNT; i++) begin
					if (r.status && !model_slot_busy[i]) begin
						model_slot_busy[i] = 1'b1;
						r.slot_granted = 4'(i);
						r.status = 1'b0;
					end
				end
			end
			REQ_UNREGISTER: begin
				model_slot_busy[sl] = 1'b0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic row_t mk_row(input logic [2:0] rq, input logic [3:0] sl,
			input logic [63:0] gl, input int reps, input bit typed, input logic e_reached,
			input logic [63:0] e_seq, input logic [3:0] e_granted, input logic e_status);
		row_t row;
		row.req = rq;
		row.slot = sl;
		row.goal = gl;
		row.reps = reps;
		row.typed = typed;
		row.reply = {e_reached, e_seq, e_granted, e_status};
		return row;
	endfunction

	// one word over start/busy; start stays high when the next word follows at once
	task automatic send_request(input logic [2:0] rq, input logic [3:0] sl,
			input logic [63:0] gl, input bit typed, input reply_t typed_reply);
		int gap;
		reply_t r;
		gap = $urandom_range(0, 5);
		if (no_gap_left > 0) begin
			gap = 0;
			no_gap_left--;
		end else if ($urandom_range(0, 40) == 0) begin
			no_gap_left = $urandom_range(5, 30);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		slot <= sl;
		goal <= gl;
		do @(posedge clk); while (busy);
		r = grace_step(rq, sl, gl);
		if (typed)
			r = typed_reply;
		pending_replies.push_back(r);
	endtask

	always @(posedge clk) begin : reply_check
		reply_t got;
		reply_t want;
		if (arst_n && done) begin
			got = {reached, seq_value, slot_granted, status};
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected word: reached=%0b seq=%h granted=%0d status=%0b",
						got.reached, got.seq_value, got.slot_granted, got.status);
			end else begin
				want = pending_replies.pop_front();
				if (got.reached !== want.reached || got.seq_value !== want.seq_value
						|| got.slot_granted !== want.slot_granted || got.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"mismatch: exp reached=%0b seq=%h granted=%0d status=%0b,",
							" got reached=%0b seq=%h granted=%0d status=%0b"},
							want.reached, want.seq_value, want.slot_granted, want.status,
							got.reached, got.seq_value, got.slot_granted, got.status);
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("quiescent_state_reclaim_tracker_core verification failed");
		$finish;
	end

	initial begin : stimulus
		int w;
		int reg_end;
		logic [2:0] rq;
		logic [3:0] sl;
		logic [63:0] gl;
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_ADVANCE;
		slot <= 4'd0;
		goal <= 64'd0;
		mismatch_count = 0;
		no_gap_left = 0;
		grace_reset();

		directed_rows[0]  = mk_row(REQ_POLL, 4'd0, 64'd1, 1, 1'b1, 1'b1, 64'd1, 4'd0, 1'b0);
		directed_rows[1]  = mk_row(REQ_POLL, 4'd0, 64'd0, 1, 1'b1, 1'b1, 64'd1, 4'd0, 1'b0);
		directed_rows[2]  = mk_row(REQ_POLL, 4'd0, 64'd3, 1, 1'b1, 1'b0, 64'd1, 4'd0, 1'b0);
		directed_rows[3]  = mk_row(REQ_ADVANCE, 4'd0, 64'd0, 1, 1'b1, 1'b0, 64'd3, 4'd0, 1'b0);
		directed_rows[4]  = mk_row(REQ_UNKNOWN_LO, 4'd0, 64'd0, 1, 1'b1, 1'b0, 64'd0, 4'd0,
			1'b0);
		directed_rows[5]  = mk_row(REQ_UNKNOWN_HI, 4'd15, '1, 1, 1'b1, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[6]  = mk_row(REQ_REGISTER, 4'd0, 64'd0, 1, 1'b1, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[7]  = mk_row(REQ_REGISTER, 4'd9, 64'd0, 1, 1'b1, 1'b0, 64'd0, 4'd1, 1'b0);
		directed_rows[8]  = mk_row(REQ_ONLINE, 4'd0, 64'd0, 1, 1'b1, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[9]  = mk_row(REQ_ADVANCE, 4'd0, 64'd0, 1, 1'b1, 1'b0, 64'd5, 4'd0, 1'b0);
		directed_rows[10] = mk_row(REQ_POLL, 4'd0, 64'd5, 1, 1'b0, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[11] = mk_row(REQ_ONLINE, 4'd15, 64'd0, 1, 1'b0, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[12] = mk_row(REQ_OFFLINE, 4'd0, 64'd0, 1, 1'b0, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[13] = mk_row(REQ_POLL, 4'd0, 64'd5, 1, 1'b0, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[14] = mk_row(REQ_POLL, 4'd0, '1, 1, 1'b0, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[15] = mk_row(REQ_POLL, 4'd0, 64'h8000_0000_0000_0000, 1, 1'b0,
			1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[16] = mk_row(REQ_OFFLINE, 4'd0, 64'd0, 1, 1'b0, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[17] = mk_row(REQ_ONLINE, 4'd15, 64'd0, 1, 1'b0, 1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[18] = mk_row(REQ_UNREGISTER, 4'd1, 64'd0, 1, 1'b0, 1'b0, 64'd0, 4'd0,
			1'b0);
		directed_rows[19] = mk_row(REQ_UNREGISTER, 4'd1, 64'd0, 1, 1'b0, 1'b0, 64'd0, 4'd0,
			1'b0);
		directed_rows[20] = mk_row(REQ_REGISTER, 4'd0, 64'd0, 15, 1'b0, 1'b0, 64'd0, 4'd0,
			1'b0);
		directed_rows[21] = mk_row(REQ_REGISTER, 4'd0, 64'd0, 1, 1'b1, 1'b0, 64'd0, 4'd0, 1'b1);
		directed_rows[22] = mk_row(REQ_UNREGISTER, 4'd15, 64'd0, 1, 1'b0, 1'b0, 64'd0, 4'd0,
			1'b0);
		directed_rows[23] = mk_row(REQ_POLL, 4'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1'b0,
			1'b0, 64'd0, 4'd0, 1'b0);
		directed_rows[24] = mk_row(REQ_ADVANCE, 4'd0, 64'd0, 3, 1'b0, 1'b0, 64'd0, 4'd0, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			for (int n = 0; n < directed_rows[k].reps; n++)
				send_request(directed_rows[k].req, directed_rows[k].slot, directed_rows[k].goal,
					directed_rows[k].typed, directed_rows[k].reply);
		end

		// alternate phases that fill and drain the slot pool
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			reg_end = ((i / 150) % 2 == 0) ? 90 : 78;
			w = $urandom_range(0, 99);
			if (w < 25)
				rq = REQ_ADVANCE;
			else if (w < 50)
				rq = REQ_POLL;
			else if (w < 62)
				rq = REQ_ONLINE;
			else if (w < 72)
				rq = REQ_OFFLINE;
			else if (w < reg_end)
				rq = REQ_REGISTER;
			else if (w < reg_end + 3)
				rq = ($urandom_range(0, 1) == 0) ? REQ_UNKNOWN_LO : REQ_UNKNOWN_HI;
			else
				rq = REQ_UNREGISTER;
			sl = 4'($urandom_range(0, QSRT_SLOT_COUNT - 1));
			case ($urandom_range(0, 7))
				0: gl = {$urandom, $urandom};
				1: gl = ($urandom_range(0, 1) == 0) ? 64'd0 : '1;
				2, 3: gl = model_read - 64'($urandom_range(0, 6)) + 64'($urandom_range(0, 6));
				4, 5: gl = model_write - 64'($urandom_range(0, 16));
				default: gl = model_write - 64'($urandom_range(0, 3)) + 64'($urandom_range(0, 3));
			endcase
			send_request(rq, sl, gl, 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_replies.size() == 0)
			$display("quiescent_state_reclaim_tracker_core verification clean");
		else
			$display("quiescent_state_reclaim_tracker_core verification failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/qsrt_pkg.sv
hw/rtl/qsrt_ram.sv
hw/rtl/qsrt_datapath.sv
hw/rtl/qsrt_ctrl.sv
hw/rtl/quiescent_state_reclaim_tracker_core.sv
verif/tb_quiescent_state_reclaim_tracker_core.sv
